// ===== rtl/core/tcw_pkg.sv =====
// Types and constants shared by the text console writer.
package tcw_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned CELL_W = 16;
  localparam int unsigned ATTR_W = 8;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

  localparam logic REG_ATTR      = 1'b0;
  localparam logic REG_CURSOR_EN = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SWEEP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic valid;
    logic use_rd;
  } pend_t;

endpackage

// ===== rtl/core/tcw_if.sv =====
// Word channels of the text console writer: command words in, result words out.
interface tcw_in_if import tcw_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, output func, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input func, input char_code, input cell_index,
                  output ready);
endinterface

interface tcw_out_if import tcw_pkg::*;;
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_position;
  logic [CELL_W-1:0] cell_value;
  logic              scrolled;
  logic              cursor_visible;

  modport source (output valid, output cursor_position, output cell_value,
                  output scrolled, output cursor_visible, input ready);
  modport sink   (input valid, input cursor_position, input cell_value,
                  input scrolled, input cursor_visible, output ready);
endinterface

// ===== rtl/core/text_console_writer_top.sv =====
// Text console writer: cell buffer memory, cursor and command sequencer.
// Put and no-op go from execute to done; an in-range read cell adds a buffer read state; scroll
// and clear sweep every buffer cell, one buffer cell a cycle, before the result word is issued.
// The sequencer takes a new word only when idle, after the last result word is registered.
// Reset: cursor homes, attribute 0x0F, cursor shown; a clearing pass then fills all
// ROWS*COLUMNS cells (2000 by default) of the buffer with blanks while no word is taken.
module text_console_writer_top import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  tcw_in_if.sink      in_i,
  tcw_out_if.source   out_o
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned ROW_W = $clog2(ROWS);
  localparam int unsigned COL_W = $clog2(COLUMNS);

  localparam logic [AW-1:0]    COLS_A     = AW'(COLUMNS);
  localparam logic [AW-1:0]    LAST_A     = AW'(CELLS - 1);
  localparam logic [AW-1:0]    SHIFT_LAST = AW'(CELLS - COLUMNS);
  localparam logic [COL_W-1:0] COL_LAST   = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W:0]   ROWS_X     = (ROW_W + 1)'(ROWS);
  localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(ROWS - 1);

  logic [CELL_W-1:0] mem [CELLS];

  state_e            state_q, state_d;
  func_e             func_q, func_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [AW-1:0]     ctr_q, ctr_d;
  logic [CELL_W-1:0] blank_q, blank_d;
  logic              scrolled_q, scrolled_d;
  logic [CELL_W-1:0] cell_q, cell_d;
  pend_t             pend_q, pend_d;
  logic [AW-1:0]     pend_addr_q, pend_addr_d;
  logic [CELL_W-1:0] rd_q;
  logic [ATTR_W-1:0] attr_q;
  logic              cen_q;

  logic              out_valid_q, out_valid_d;
  logic [POS_W-1:0]  out_pos_q, out_pos_d;
  logic [CELL_W-1:0] out_cell_q, out_cell_d;
  logic              out_scr_q, out_scr_d;
  logic              out_vis_q, out_vis_d;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     cur_addr;
  logic [ROW_W:0]    row_n;
  logic [COL_W-1:0]  col_n;
  logic              cfg_we;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
      cen_q  <= 1'b1;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_ATTR:      attr_q <= pwdata[ATTR_W-1:0];
        REG_CURSOR_EN: cen_q  <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ATTR:      prdata = {{(32 - ATTR_W){1'b0}}, attr_q};
      REG_CURSOR_EN: prdata = {31'b0, cen_q};
    endcase
  end

  // cell buffer
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign cur_addr = AW'(AW'(row_q) * COLS_A + AW'(col_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      row_q       <= '0;
      col_q       <= '0;
      ctr_q       <= '0;
      blank_q     <= {ATTR_RESET, CH_SPACE};
      scrolled_q  <= 1'b0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      ctr_q       <= ctr_d;
      blank_q     <= blank_d;
      scrolled_q  <= scrolled_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    char_q      <= char_d;
    idx_q       <= idx_d;
    cell_q      <= cell_d;
    pend_addr_q <= pend_addr_d;
    out_pos_q   <= out_pos_d;
    out_cell_q  <= out_cell_d;
    out_scr_q   <= out_scr_d;
    out_vis_q   <= out_vis_d;
  end

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    char_d      = char_q;
    idx_d       = idx_q;
    row_d       = row_q;
    col_d       = col_q;
    ctr_d       = ctr_q;
    blank_d     = blank_q;
    scrolled_d  = scrolled_q;
    cell_d      = cell_q;
    pend_d      = '0;
    pend_addr_d = pend_addr_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_pos_d   = out_pos_q;
    out_cell_d  = out_cell_q;
    out_scr_d   = out_scr_q;
    out_vis_d   = out_vis_q;
    in_i.ready  = (state_q == ST_IDLE);
    row_n       = {1'b0, row_q};
    col_n       = col_q;

    mem_we    = pend_q.valid;
    mem_waddr = pend_addr_q;
    mem_wdata = pend_q.use_rd ? rd_q : blank_q;
    mem_re    = 1'b0;
    mem_raddr = AW'(ctr_q + COLS_A);

    unique case (state_q)
      ST_INIT, ST_SWEEP: begin
        pend_d.valid = 1'b1;
        pend_addr_d  = ctr_q;
        if (scrolled_q && (ctr_q < SHIFT_LAST)) begin
          mem_re        = 1'b1;
          pend_d.use_rd = 1'b1;
        end
        if (ctr_q == LAST_A) begin
          ctr_d   = '0;
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
        end else begin
          ctr_d = AW'(ctr_q + AW'(1));
        end
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          func_d     = func_e'(in_i.func);
          char_d     = in_i.char_code;
          idx_d      = in_i.cell_index;
          scrolled_d = 1'b0;
          cell_d     = '0;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (func_q)
          FUNC_PUT: begin
            priority if (char_q == CH_NEWLINE) begin
              col_n = '0;
              row_n = {1'b0, row_q} + (ROW_W + 1)'(1);
            end else if (char_q == CH_BACKSPACE) begin
              if (col_q != '0) begin
                col_n     = COL_W'(col_q - 1'b1);
                mem_we    = 1'b1;
                mem_waddr = AW'(cur_addr - AW'(1));
                mem_wdata = {attr_q, CH_SPACE};
              end
            end else begin
              mem_we    = 1'b1;
              mem_waddr = cur_addr;
              mem_wdata = {attr_q, char_q};
              if (col_q == COL_LAST) begin
                col_n = '0;
                row_n = {1'b0, row_q} + (ROW_W + 1)'(1);
              end else begin
                col_n = COL_W'(col_q + 1'b1);
              end
            end
            col_d = col_n;
            if (row_n >= ROWS_X) begin
              row_d      = ROW_LAST;
              scrolled_d = 1'b1;
              blank_d    = {attr_q, CH_SPACE};
              ctr_d      = '0;
              state_d    = ST_SWEEP;
            end else begin
              row_d   = row_n[ROW_W-1:0];
              state_d = ST_DONE;
            end
          end
          FUNC_CLEAR: begin
            row_d   = '0;
            col_d   = '0;
            blank_d = {attr_q, CH_SPACE};
            ctr_d   = '0;
            state_d = ST_SWEEP;
          end
          FUNC_READ: begin
            if (32'(idx_q) < CELLS) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(idx_q);
              state_d   = ST_READ;
            end else begin
              state_d = ST_DONE;
            end
          end
          FUNC_NOP: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_READ: begin
        cell_d  = rd_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_pos_d   = POS_W'(cur_addr);
          out_cell_d  = cell_q;
          out_scr_d   = scrolled_q;
          out_vis_d   = cen_q;
          state_d     = ST_IDLE;
        end
      end
    endcase
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.cursor_position = out_pos_q;
  assign out_o.cell_value      = out_cell_q;
  assign out_o.scrolled        = out_scr_q;
  assign out_o.cursor_visible  = out_vis_q;

endmodule

// ===== dv/text_console_writer_top_test.sv =====
`timescale 1ns / 1ps
// Testbench for the text console writer: random and directed commands checked against a shadow console.
module text_console_writer_top_test;
  import tcw_pkg::*;

  localparam int unsigned COLUMNS     = 80;
  localparam int unsigned ROWS        = 25;
  localparam int unsigned CELLS       = COLUMNS * ROWS;
  localparam int unsigned PHASE_CMDS  = 400;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned END_SLACK   = 16;
  localparam int unsigned CYCLE_LIMIT = 20_000_000;

  localparam logic [2:0] ADDR_ATTR      = {REG_ATTR, 2'b00};
  localparam logic [2:0] ADDR_CURSOR_EN = {REG_CURSOR_EN, 2'b00};

  typedef struct packed {
    func_e             func;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } console_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
    logic              cursor_visible;
  } console_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tcw_in_if  cmd_if ();
  tcw_out_if res_if ();

  text_console_writer_top #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  console_cmd_t    cmd_q[$];
  console_result_t result_q[$];
  console_cmd_t    offered;

  logic [CELL_W-1:0] cells[CELLS];
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [ATTR_W-1:0] shadow_attr;
  logic              shadow_cursor_en;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_go        = 1'b0;
  logic        hold_seen;
  int unsigned hold_left;

  int unsigned queued_count   = 0;
  int unsigned taken_count    = 0;
  int unsigned checked_count  = 0;
  int unsigned put_count      = 0;
  int unsigned read_count     = 0;
  int unsigned clear_count    = 0;
  int unsigned scroll_count   = 0;
  int unsigned settings_count = 0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               result_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH at result %0d: %s got 0x%0h want 0x%0h", checked_count, what, got,
             want);
    fail_count++;
  endtask

  function automatic logic console_put(logic [CHAR_W-1:0] ch);
    int unsigned i;
    if (ch == CH_NEWLINE) begin
      cur_col = 0;
      cur_row++;
    end else if (ch == CH_BACKSPACE) begin
      if (cur_col > 0) begin
        cur_col--;
        cells[cur_row * COLUMNS + cur_col] = {shadow_attr, CH_SPACE};
      end
      return 1'b0;
    end else begin
      cells[cur_row * COLUMNS + cur_col] = {shadow_attr, ch};
      cur_col++;
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_row++;
      end
    end
    if (cur_row >= ROWS) begin
      for (i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
      for (i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = {shadow_attr, CH_SPACE};
      cur_row = ROWS - 1;
      scroll_count++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic console_result_t console_apply(console_cmd_t cmd);
    console_result_t r;
    int unsigned     i;
    r = '0;
    case (cmd.func)
      FUNC_PUT: begin
        put_count++;
        r.scrolled = console_put(cmd.char_code);
      end
      FUNC_CLEAR: begin
        clear_count++;
        for (i = 0; i < CELLS; i++) cells[i] = {shadow_attr, CH_SPACE};
        cur_row = 0;
        cur_col = 0;
      end
      FUNC_READ: begin
        read_count++;
        if (cmd.cell_index < CELLS) r.cell_value = cells[cmd.cell_index];
      end
      default: ;
    endcase
    r.cursor_position = POS_W'(cur_row * COLUMNS + cur_col);
    r.cursor_visible  = shadow_cursor_en;
    return r;
  endfunction

  // Offer the next word; hold it until taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid      <= 1'b0;
      cmd_if.func       <= FUNC_PUT;
      cmd_if.char_code  <= '0;
      cmd_if.cell_index <= '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        result_q.push_back(console_apply(offered));
        taken_count++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered = cmd_q.pop_front();
          cmd_if.valid      <= 1'b1;
          cmd_if.func       <= offered.func;
          cmd_if.char_code  <= offered.char_code;
          cmd_if.cell_index <= offered.cell_index;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_go != hold_seen) begin
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_go;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    console_result_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected word, cursor_position", res_if.cursor_position, 0);
        end else begin
          want = result_q.pop_front();
          if (res_if.cursor_position !== want.cursor_position)
            report_mismatch("cursor_position", res_if.cursor_position, want.cursor_position);
          if (res_if.cell_value !== want.cell_value)
            report_mismatch("cell_value", res_if.cell_value, want.cell_value);
          if (res_if.scrolled !== want.scrolled)
            report_mismatch("scrolled", res_if.scrolled, want.scrolled);
          if (res_if.cursor_visible !== want.cursor_visible)
            report_mismatch("cursor_visible", res_if.cursor_visible, want.cursor_visible);
        end
        checked_count++;
      end
      res_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic void queue_cmd(func_e f, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
    console_cmd_t c;
    c.func       = f;
    c.char_code  = ch;
    c.cell_index = idx;
    cmd_q.push_back(c);
    queued_count++;
  endfunction

  function automatic logic [CHAR_W-1:0] text_char();
    logic [CHAR_W-1:0] ch;
    ch = CHAR_W'($urandom_range(0, 255));
    while (ch == CH_NEWLINE || ch == CH_BACKSPACE) ch = CHAR_W'($urandom_range(0, 255));
    return ch;
  endfunction

  function automatic logic [IDX_W-1:0] read_index();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return IDX_W'($urandom_range(CELLS - COLUMNS, CELLS - 1));
    if (pick < 80) return IDX_W'($urandom_range(0, CELLS - 1));
    if (pick < 90) return IDX_W'($urandom_range(CELLS - 4, CELLS + 3));
    return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
  endfunction

  // Mostly text lines with random content, with edits, reads and some noise.
  function automatic void queue_session(int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n;
    int unsigned i;
    stop_at = queued_count + count;
    while (queued_count < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 170) : $urandom_range(0, 30);
        for (i = 0; i < n; i++) queue_cmd(FUNC_PUT, text_char(), IDX_W'($urandom()));
        if ($urandom_range(0, 9) < 8) queue_cmd(FUNC_PUT, CH_NEWLINE, IDX_W'($urandom()));
      end else if (pick < 65) begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) queue_cmd(FUNC_PUT, CH_BACKSPACE, IDX_W'($urandom()));
      end else if (pick < 83) begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) queue_cmd(FUNC_READ, CHAR_W'($urandom()), read_index());
      end else if (pick < 88) begin
        queue_cmd(FUNC_NOP, CHAR_W'($urandom()), IDX_W'($urandom()));
      end else if (pick < 90) begin
        queue_cmd(FUNC_CLEAR, CHAR_W'($urandom()), IDX_W'($urandom()));
      end else begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++)
          queue_cmd(func_e'($urandom_range(0, 3)), CHAR_W'($urandom()), IDX_W'($urandom()));
      end
    end
  endfunction

  task automatic reg_access(logic [2:0] addr, logic wr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_console(logic [ATTR_W-1:0] attr, logic cursor_en);
    logic [31:0] rd;
    logic [31:0] noise;
    noise = $urandom();
    reg_access(ADDR_ATTR, 1'b1, {noise[31:ATTR_W], attr}, rd);
    shadow_attr = attr;
    reg_access(ADDR_CURSOR_EN, 1'b1, {noise[31:1], cursor_en}, rd);
    shadow_cursor_en = cursor_en;
    reg_access(ADDR_ATTR, 1'b0, '0, rd);
    if (rd !== 32'(attr)) report_mismatch("text_attribute readback", rd, attr);
    reg_access(ADDR_CURSOR_EN, 1'b0, '0, rd);
    if (rd !== 32'(cursor_en)) report_mismatch("cursor_enabled readback", rd, cursor_en);
    settings_count++;
  endtask

  task automatic drain();
    while (cmd_q.size() != 0 || cmd_if.valid || result_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned i;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_ni  = 1'b0;
    for (i = 0; i < CELLS; i++) cells[i] = {ATTR_RESET, CH_SPACE};
    cur_row          = 0;
    cur_col          = 0;
    shadow_attr      = ATTR_RESET;
    shadow_cursor_en = 1'b1;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Backspace at column zero, reset contents, out-of-range reads, byte extremes.
    queue_cmd(FUNC_PUT, CH_BACKSPACE, '0);
    queue_cmd(FUNC_READ, '0, IDX_W'(0));
    queue_cmd(FUNC_READ, '1, IDX_W'(CELLS - 1));
    queue_cmd(FUNC_READ, '0, IDX_W'(CELLS));
    queue_cmd(FUNC_READ, '0, '1);
    queue_cmd(FUNC_PUT, 8'h00, '0);
    queue_cmd(FUNC_PUT, 8'hFF, '1);
    queue_cmd(FUNC_PUT, 8'h41, '0);
    queue_cmd(FUNC_PUT, CH_BACKSPACE, '0);
    queue_cmd(FUNC_READ, '0, IDX_W'(1));
    queue_cmd(FUNC_READ, '0, IDX_W'(2));
    queue_cmd(FUNC_NOP, '1, '1);
    queue_cmd(FUNC_NOP, '0, '0);
    queue_cmd(FUNC_PUT, CH_NEWLINE, '0);
    queue_cmd(FUNC_PUT, 8'h7F, '0);
    queue_cmd(FUNC_READ, '0, IDX_W'(COLUMNS));
    queue_cmd(FUNC_READ, '0, IDX_W'(1024));
    queue_cmd(FUNC_CLEAR, '1, '1);
    queue_cmd(FUNC_READ, '0, IDX_W'(COLUMNS));
    queue_cmd(FUNC_READ, '0, IDX_W'(0));
    drain();

    set_console(ATTR_W'($urandom_range(0, 255)), 1'b1);
    queue_session(PHASE_CMDS);
    hold_go = ~hold_go;
    drain();

    set_console('0, 1'b0);
    send_idle_pct = 74;
    queue_session(PHASE_CMDS);
    drain();

    set_console('1, 1'b1);
    send_idle_pct  = 0;
    recv_stall_pct = 74;
    queue_session(PHASE_CMDS);
    drain();

    set_console(ATTR_W'($urandom_range(0, 255)), 1'b0);
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    queue_session(PHASE_CMDS);
    drain();

    repeat (END_SLACK) @(negedge clk_i);
    $display("Ran %0d commands: %0d puts, %0d reads, %0d clears, %0d scrolls", taken_count,
             put_count, read_count, clear_count, scroll_count);
    $display("Checked %0d result words over %0d register settings, %0d mismatches",
             checked_count, settings_count, fail_count);
    if (fail_count == 0 && result_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== text_console_writer_top.f =====
rtl/core/tcw_pkg.sv
rtl/core/tcw_if.sv
rtl/core/text_console_writer_top.sv
dv/text_console_writer_top_test.sv
